// ===== design/pts_pkg.sv =====
`default_nettype none

package pts_pkg;

    localparam logic [1:0] ACT_REGISTER = 2'd0;
    localparam logic [1:0] ACT_DELAY    = 2'd1;
    localparam logic [1:0] ACT_TICK     = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_PRIO   = 2'd1;
    localparam logic [1:0] ST_IDLE_DELAY = 2'd2;
    localparam logic [1:0] ST_ZERO_DELAY = 2'd3;

    typedef struct packed {
        logic in_ready;
        logic exec;
        logic tick_start;
        logic tick_step;
        logic decide;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic is_tick;
        logic walk_last;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

// ===== design/pts_in_if.sv =====
`default_nettype none

interface pts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [5:0]  priority_req;
    logic [15:0] delay_ticks;

    modport source (output valid, output action, output priority_req, output delay_ticks,
                    input ready);
    modport sink (input valid, input action, input priority_req, input delay_ticks,
                  output ready);
endinterface

`default_nettype wire

// ===== design/pts_out_if.sv =====
`default_nettype none

interface pts_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  next_priority;
    logic        switch_needed;
    logic [1:0]  status;
    logic [31:0] ready_mask;

    modport source (output valid, output next_priority, output switch_needed, output status,
                    output ready_mask, input ready);
    modport sink (input valid, input next_priority, input switch_needed, input status,
                  input ready_mask, output ready);
endinterface

`default_nettype wire

// ===== design/pts_ctrl.sv =====
`default_nettype none

module pts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  pts_pkg::stat_t stat,
    output pts_pkg::cmd_t  cmd
);
    import pts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.is_tick ? S_TICK : S_DECIDE;
            end
            S_TICK:
            begin
                if (stat.walk_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd.in_ready   = (state_reg == S_IDLE);
        cmd.exec       = (state_reg == S_EXEC);
        cmd.tick_start = (state_reg == S_EXEC);
        cmd.tick_step  = (state_reg == S_TICK);
        cmd.decide     = (state_reg == S_DECIDE) && !stat.out_busy;
    end

endmodule

`default_nettype wire

// ===== design/pts_dp.sv =====
`default_nettype none

module pts_dp #(
    parameter int NUM_PRIORITIES = 32,
    parameter int TIMEOUT_BITS   = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    pts_in_if.sink         in_ch,
    pts_out_if.source      out_ch,
    input  pts_pkg::cmd_t  cmd,
    output pts_pkg::stat_t stat
);
    import pts_pkg::*;

    localparam int AW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int CW = $clog2(NUM_PRIORITIES + 1);
    localparam logic [31:0] TMAX = 32'((64'd1 << TIMEOUT_BITS) - 64'd1);

    logic [1:0]                action_reg;
    logic [5:0]                prio_reg;
    logic [15:0]               ticks_reg;
    logic [1:0]                status_reg;
    logic [1:0]                status_next;
    logic [NUM_PRIORITIES-1:0] ready_reg;
    logic [NUM_PRIORITIES-1:0] ready_next;
    logic [NUM_PRIORITIES-1:0] delayed_reg;
    logic [NUM_PRIORITIES-1:0] delayed_next;
    logic [NUM_PRIORITIES:0]   registered_reg;
    logic [NUM_PRIORITIES:0]   registered_next;
    logic [CW-1:0]             cur_reg;
    logic [CW-1:0]             walk_reg;

    logic                      out_valid_reg;
    logic [5:0]                out_prio_reg;
    logic                      out_switch_reg;
    logic [1:0]                out_status_reg;
    logic [31:0]               out_mask_reg;

    logic [TIMEOUT_BITS-1:0]   timeout_mem [NUM_PRIORITIES];
    logic [TIMEOUT_BITS-1:0]   rd_data_reg;

    logic                      prio_ok;
    logic [CW-1:0]             prio_idx;
    logic [CW-1:0]             prio_m1;
    logic [AW-1:0]             prio_bit;
    logic [CW-1:0]             cur_m1;
    logic [AW-1:0]             cur_addr;
    logic [31:0]               ticks_wide;
    logic [31:0]               ticks_sat;
    logic [CW-1:0]             walk_m1;
    logic [AW-1:0]             ent;
    logic [TIMEOUT_BITS-1:0]   dec;
    logic                      proc;
    logic                      rd_en;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [TIMEOUT_BITS-1:0]   wr_data;
    logic [CW-1:0]             top;

    function automatic logic [CW-1:0] top_of(input logic [NUM_PRIORITIES-1:0] s);
        logic [CW-1:0] t;
        t = '0;
        for (int p = 0; p < NUM_PRIORITIES; p++)
        begin
            if (s[p])
            begin
                t = CW'(p + 1);
            end
        end
        return t;
    endfunction

    assign in_ch.ready = cmd.in_ready;

    assign prio_ok    = (32'(prio_reg) <= 32'(NUM_PRIORITIES));
    assign prio_idx   = prio_reg[CW-1:0];
    assign prio_m1    = prio_idx - CW'(1);
    assign prio_bit   = prio_m1[AW-1:0];
    assign cur_m1     = cur_reg - CW'(1);
    assign cur_addr   = cur_m1[AW-1:0];
    assign ticks_wide = {16'b0, ticks_reg};
    assign ticks_sat  = (ticks_wide > TMAX) ? TMAX : ticks_wide;
    assign walk_m1    = walk_reg - CW'(1);
    assign ent        = walk_m1[AW-1:0];
    assign dec        = (rd_data_reg != '0) ? rd_data_reg - TIMEOUT_BITS'(1) : rd_data_reg;
    assign proc       = cmd.tick_step && (walk_reg != '0) && delayed_reg[ent];
    assign rd_en      = cmd.tick_step && (walk_reg < CW'(NUM_PRIORITIES));
    assign top        = top_of(ready_reg);

    assign stat.in_valid  = in_ch.valid;
    assign stat.is_tick   = (action_reg == ACT_TICK);
    assign stat.walk_last = (walk_reg == CW'(NUM_PRIORITIES));
    assign stat.out_busy  = out_valid_reg && !out_ch.ready;

    always_comb
    begin
        status_next     = status_reg;
        ready_next      = ready_reg;
        delayed_next    = delayed_reg;
        registered_next = registered_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_addr;
        wr_data         = TIMEOUT_BITS'(ticks_sat);
        if (cmd.exec)
        begin
            status_next = ST_OK;
            case (action_reg)
                ACT_REGISTER:
                begin
                    if (!prio_ok || registered_reg[prio_idx])
                    begin
                        status_next = ST_BAD_PRIO;
                    end
                    else
                    begin
                        registered_next[prio_idx] = 1'b1;
                        if (prio_idx != '0)
                        begin
                            ready_next[prio_bit] = 1'b1;
                        end
                    end
                end
                ACT_DELAY:
                begin
                    if (cur_reg == '0)
                    begin
                        status_next = ST_IDLE_DELAY;
                    end
                    else if (ticks_reg == '0)
                    begin
                        status_next = ST_ZERO_DELAY;
                    end
                    else
                    begin
                        wr_en                  = 1'b1;
                        ready_next[cur_addr]   = 1'b0;
                        delayed_next[cur_addr] = 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
        if (proc)
        begin
            wr_en   = 1'b1;
            wr_addr = ent;
            wr_data = dec;
            if (dec == '0)
            begin
                ready_next[ent]   = 1'b1;
                delayed_next[ent] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            timeout_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= timeout_mem[walk_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && cmd.in_ready)
        begin
            action_reg <= in_ch.action;
            prio_reg   <= in_ch.priority_req;
            ticks_reg  <= in_ch.delay_ticks;
        end
        status_reg <= status_next;
        if (cmd.decide)
        begin
            out_prio_reg   <= 6'(top);
            out_switch_reg <= (top != cur_reg);
            out_status_reg <= status_reg;
            out_mask_reg   <= 32'(ready_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg      <= '0;
            delayed_reg    <= '0;
            registered_reg <= '0;
            cur_reg        <= '0;
            walk_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ready_reg      <= ready_next;
            delayed_reg    <= delayed_next;
            registered_reg <= registered_next;
            if (cmd.tick_start)
            begin
                walk_reg <= '0;
            end
            else if (cmd.tick_step)
            begin
                walk_reg <= walk_reg + CW'(1);
            end
            if (cmd.decide)
            begin
                cur_reg       <= top;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.next_priority = out_prio_reg;
    assign out_ch.switch_needed = out_switch_reg;
    assign out_ch.status        = out_status_reg;
    assign out_ch.ready_mask    = out_mask_reg;

endmodule

`default_nettype wire

// ===== design/priority_thread_scheduler_unit.sv =====
// priority scheduler for NUM_PRIORITIES thread priorities plus the idle thread
// in_ch: one beat is one event (register a thread, delay the running thread,
//   or one timer tick); out_ch: one beat per event with the scheduling decision,
//   switch flag, status code and the ready set after the event
// in_ch.ready is high only while no event is in flight; a finished result sits
//   in the output register, so the next event can be taken while it waits
// register and delay events: the event is executed, then the decision is
//   registered in the output register; the next event waits for the decision
// tick events: the tick walks every timeout entry in one memory with a read port
//   and a write port, one entry per cycle with registered read data
// if the output register still holds an untaken result when a decision is due,
//   the block holds in its decision step until that result is taken; no beat is lost
// reset clears the ready, delayed and registered sets and makes the idle
//   thread current; the timeout memory is not cleared, and an entry's read data
//   is used only after a delay has written it
`default_nettype none

module priority_thread_scheduler_unit #(
    parameter int NUM_PRIORITIES = 32,
    parameter int TIMEOUT_BITS   = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    pts_in_if.sink    in_ch,
    pts_out_if.source out_ch
);
    import pts_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    pts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    pts_dp #(
        .NUM_PRIORITIES (NUM_PRIORITIES),
        .TIMEOUT_BITS   (TIMEOUT_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule

`default_nettype wire

// ===== verif/priority_thread_scheduler_unit_test.sv =====
module priority_thread_scheduler_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam int NUM_PRIO      = 32;
    localparam int TIMEOUT_W     = 16;
    localparam int RANDOM_EVENTS = 1825;
    localparam int IDLE_LIMIT    = 2000;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 60;

    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [5:0]  next_priority;
        logic        switch_needed;
        logic [1:0]  status;
        logic [31:0] ready_mask;
    } decision_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  priority_req;
        logic [15:0] delay_ticks;
        logic        fixed;
        decision_t   decision;
    } script_row_t;

    localparam int SCRIPT_LEN = 24;

    script_row_t script [SCRIPT_LEN] = '{
        '{ACT_TICK,     6'd0,  16'd0,      1'b1, '{6'd0,  1'b0, ST_OK,         32'h0}},
        '{ACT_DELAY,    6'd0,  16'd5,      1'b1, '{6'd0,  1'b0, ST_IDLE_DELAY, 32'h0}},
        '{ACT_REGISTER, 6'd33, 16'd0,      1'b1, '{6'd0,  1'b0, ST_BAD_PRIO,   32'h0}},
        '{ACT_REGISTER, 6'd63, 16'hffff,   1'b1, '{6'd0,  1'b0, ST_BAD_PRIO,   32'h0}},
        '{ACT_NONE,     6'd42, 16'd1234,   1'b1, '{6'd0,  1'b0, ST_OK,         32'h0}},
        '{ACT_REGISTER, 6'd0,  16'd0,      1'b1, '{6'd0,  1'b0, ST_OK,         32'h0}},
        '{ACT_REGISTER, 6'd0,  16'd0,      1'b1, '{6'd0,  1'b0, ST_BAD_PRIO,   32'h0}},
        '{ACT_REGISTER, 6'd1,  16'd0,      1'b1, '{6'd1,  1'b1, ST_OK,         32'h1}},
        '{ACT_DELAY,    6'd0,  16'd0,      1'b1, '{6'd1,  1'b0, ST_ZERO_DELAY, 32'h1}},
        '{ACT_DELAY,    6'd63, 16'hffff,   1'b1, '{6'd0,  1'b1, ST_OK,         32'h0}},
        '{ACT_DELAY,    6'd0,  16'd0,      1'b1, '{6'd0,  1'b0, ST_IDLE_DELAY, 32'h0}},
        '{ACT_REGISTER, 6'd32, 16'd0,      1'b1, '{6'd32, 1'b1, ST_OK,  32'h8000_0000}},
        '{ACT_REGISTER, 6'd32, 16'd0,      1'b1, '{6'd32, 1'b0, ST_BAD_PRIO,
                                                   32'h8000_0000}},
        '{ACT_REGISTER, 6'd16, 16'd0,      1'b1, '{6'd32, 1'b0, ST_OK,  32'h8000_8000}},
        '{ACT_DELAY,    6'd0,  16'd1,      1'b0, '0},
        '{ACT_TICK,     6'd0,  16'd0,      1'b0, '0},
        '{ACT_DELAY,    6'd0,  16'd2,      1'b0, '0},
        '{ACT_REGISTER, 6'd31, 16'd0,      1'b0, '0},
        '{ACT_DELAY,    6'd0,  16'd1,      1'b0, '0},
        '{ACT_TICK,     6'd21, 16'h00ff,   1'b0, '0},
        '{ACT_TICK,     6'd0,  16'd0,      1'b0, '0},
        '{ACT_NONE,     6'd42, 16'h5555,   1'b0, '0},
        '{ACT_DELAY,    6'd0,  16'd3,      1'b0, '0},
        '{ACT_REGISTER, 6'd21, 16'haaaa,   1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pts_in_if  in_ch ();
    pts_out_if out_ch ();

    priority_thread_scheduler_unit #(
        .NUM_PRIORITIES(NUM_PRIO),
        .TIMEOUT_BITS  (TIMEOUT_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    always #1 clk = ~clk;

    logic [31:0]          ready_bits;
    logic [31:0]          delayed_bits;
    logic [32:0]          taken;
    logic [TIMEOUT_W-1:0] countdown [32];
    logic [5:0]           running;

    decision_t decision_q [$];
    bit        failed;
    int        beats_seen;
    int        burst_left;
    int        idle_cycles;

    function automatic decision_t schedule_event(logic [1:0] action, logic [5:0] prio,
                                                 logic [15:0] ticks);
        decision_t  d;
        logic [1:0] st;
        logic [5:0] top;
        st = ST_OK;
        case (action)
            ACT_REGISTER:
            begin
                if (prio > NUM_PRIO)
                    st = ST_BAD_PRIO;
                else if (taken[prio])
                    st = ST_BAD_PRIO;
                else
                begin
                    taken[prio] = 1'b1;
                    if (prio != 0)
                        ready_bits[prio - 1] = 1'b1;
                end
            end
            ACT_DELAY:
            begin
                if (running == 0)
                    st = ST_IDLE_DELAY;
                else if (ticks == 0)
                    st = ST_ZERO_DELAY;
                else
                begin
                    countdown[running - 1] = ticks;
                    ready_bits[running - 1] = 1'b0;
                    delayed_bits[running - 1] = 1'b1;
                end
            end
            ACT_TICK:
            begin
                for (int i = 0; i < NUM_PRIO; i++)
                begin
                    if (delayed_bits[i])
                    begin
                        if (countdown[i] != 0)
                            countdown[i] = countdown[i] - 1'b1;
                        if (countdown[i] == 0)
                        begin
                            ready_bits[i] = 1'b1;
                            delayed_bits[i] = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        top = '0;
        for (int p = 1; p <= NUM_PRIO; p++)
        begin
            if (ready_bits[p - 1])
                top = 6'(p);
        end
        d.next_priority = top;
        d.switch_needed = (top != running);
        d.status        = st;
        d.ready_mask    = ready_bits;
        running = top;
        return d;
    endfunction

    task automatic offer_event(logic [1:0] action, logic [5:0] prio, logic [15:0] ticks,
                               logic fixed, decision_t typed);
        decision_t predicted;
        int        gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.action       <= action;
        in_ch.priority_req <= prio;
        in_ch.delay_ticks  <= ticks;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predicted = schedule_event(action, prio, ticks);
        decision_q.push_back(fixed ? typed : predicted);
        @(negedge clk);
    endtask

    // receiver stall patterns, plus one long hold-off to back up the input
    int  stall_mode;
    int  stall_left;
    int  hold_left;
    bit  held_once;
    int  rx_phase;

    always @(negedge clk)
    begin
        rx_phase++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (!held_once && beats_seen >= 400)
        begin
            held_once = 1'b1;
            hold_left = LONG_HOLD - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 120);
            end
            stall_left--;
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= ((rx_phase % 4) == 0);
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        decision_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            beats_seen++;
            if (decision_q.size() == 0)
            begin
                $error("result beat with no event pending: next_priority %0d",
                       out_ch.next_priority);
                failed = 1'b1;
            end
            else
            begin
                want = decision_q.pop_front();
                if (out_ch.next_priority !== want.next_priority)
                begin
                    $error("next_priority expected %0d actual %0d",
                           want.next_priority, out_ch.next_priority);
                    failed = 1'b1;
                end
                if (out_ch.switch_needed !== want.switch_needed)
                begin
                    $error("switch_needed expected %0d actual %0d",
                           want.switch_needed, out_ch.switch_needed);
                    failed = 1'b1;
                end
                if (out_ch.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, out_ch.status);
                    failed = 1'b1;
                end
                if (out_ch.ready_mask !== want.ready_mask)
                begin
                    $error("ready_mask expected %h actual %h",
                           want.ready_mask, out_ch.ready_mask);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [1:0]  act;
        logic [5:0]  prio;
        logic [15:0] ticks;
        int          pick;
        int          sel;

        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_REGISTER;
        in_ch.priority_req = '0;
        in_ch.delay_ticks  = '0;
        out_ch.ready       = 1'b0;

        ready_bits   = '0;
        delayed_bits = '0;
        taken        = '0;
        running      = '0;
        for (int i = 0; i < 32; i++)
            countdown[i] = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int n = 0; n < SCRIPT_LEN; n++)
            offer_event(script[n].action, script[n].priority_req, script[n].delay_ticks,
                        script[n].fixed, script[n].decision);

        for (int n = 0; n < RANDOM_EVENTS; n++)
        begin
            pick  = $urandom_range(0, 99);
            prio  = 6'($urandom_range(0, 63));
            ticks = 16'($urandom);
            if (pick < 10)
            begin
                act = ACT_REGISTER;
                if ($urandom_range(0, 4) != 0)
                    prio = 6'($urandom_range(1, NUM_PRIO));
            end
            else if (pick < 45)
            begin
                act = ACT_DELAY;
                sel = $urandom_range(0, 299);
                if (sel < 8)
                    ticks = '0;
                else if (sel == 8)
                    ticks = 16'($urandom);
                else if (sel < 25)
                    ticks = 16'($urandom_range(13, 200));
                else
                    ticks = 16'($urandom_range(1, 12));
            end
            else if (pick < 95)
                act = ACT_TICK;
            else
                act = ACT_NONE;
            offer_event(act, prio, ticks, 1'b0, '0);
        end
        in_ch.valid <= 1'b0;

        while (decision_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failed)
            $display("simulation failed");
        else
            $display("simulation ok");
        $finish;
    end

endmodule
